// ===== sv/pba_pkg.sv =====
// Package for the power-of-two bin block allocator.
// Holds the pool geometry, field widths, codes and the result word type.
// No dependencies; every other file of the block but pba_ram imports it.
package pba_pkg;

    localparam int POOL_CHUNKS_DEF = 4;
    localparam int CHUNK_BYTES     = 65536;
    localparam int PAGE_BYTES      = 4096;
    localparam int NUM_BINS        = 8;
    localparam int MIN_BLOCK       = 32;
    localparam int HDR_BYTES       = 8;

    localparam int MIN_SHIFT   = $clog2(MIN_BLOCK);
    localparam int CHUNK_UNITS = CHUNK_BYTES / MIN_BLOCK;
    localparam int CHUNK_SHIFT = $clog2(CHUNK_UNITS);
    localparam int PAGE_UNITS  = PAGE_BYTES / MIN_BLOCK;
    localparam int PAGE_SHIFT  = $clog2(PAGE_UNITS);
    localparam int PAGES       = CHUNK_BYTES / PAGE_BYTES;
    localparam int PAGE_W      = $clog2(PAGES);
    localparam int BIN_W       = 3;
    localparam int TOP_BIN     = NUM_BINS - 1;
    localparam int TOP_SIZE    = MIN_BLOCK << TOP_BIN;

    localparam int ADDR_W = 18;
    localparam int REQ_W  = 16;
    localparam int SIZE_W = 13;
    localparam int STAT_W = 2;
    localparam int NEED_W = REQ_W + 1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TOO_LARGE = 2'd2
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        status_t           status;
    } result_t;

endpackage

// ===== sv/pba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pba_outbuf.sv =====
// Output register between the allocator sequencer and the result channel.
// Depends on pba_pkg for the result word type.
module pba_outbuf
    import pba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    output logic                res_ready,
    input  result_t             res,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   granted_address,
    output logic [SIZE_W-1:0]   granted_size,
    output logic [STAT_W-1:0]   status
);

    logic    valid_reg;
    result_t data_reg;

    assign res_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid       = valid_reg;
    assign granted_address = data_reg.addr;
    assign granted_size    = data_reg.size;
    assign status          = data_reg.status;

endmodule

// ===== sv/pba_ctrl.sv =====
// Sequencer of the allocator: bin heads, chunk count, and the read-modify-write
// steps on the link and tag memories. Depends on pba_pkg.
module pba_ctrl
    import pba_pkg::*;
#(
    parameter int POOL_CHUNKS = POOL_CHUNKS_DEF,
    parameter int UNITS       = POOL_CHUNKS_DEF * CHUNK_UNITS,
    parameter int UNIT_W      = $clog2(POOL_CHUNKS_DEF * CHUNK_UNITS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [REQ_W-1:0]   request_size,
    input  logic [ADDR_W-1:0]  release_address,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               link_we,
    output logic [UNIT_W-1:0]  link_waddr,
    output logic [UNIT_W:0]    link_wdata,
    output logic [UNIT_W-1:0]  link_raddr,
    input  logic [UNIT_W:0]    link_rdata,
    output logic               tag_we,
    output logic [UNIT_W-1:0]  tag_waddr,
    output logic [BIN_W-1:0]   tag_wdata,
    output logic [UNIT_W-1:0]  tag_raddr,
    input  logic [BIN_W-1:0]   tag_rdata
);

    localparam int CNT_W = $clog2(POOL_CHUNKS + 1);
    localparam int LIM_W = CNT_W + CHUNK_SHIFT;
    localparam int AU_W  = ADDR_W - MIN_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE, S_REFILL, S_POP_RD, S_POP_WB, S_SPLIT, S_GRANT, S_FREE_RD, S_FREE_WB
    } state_t;

    state_t               state_reg;
    logic                 done_reg;
    logic [BIN_W-1:0]     bin_reg;
    logic [BIN_W-1:0]     lvl_reg;
    logic [UNIT_W-1:0]    unit_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [CNT_W-1:0]     chunks_reg;
    result_t              res_reg;
    logic [NUM_BINS-1:0]  head_valid_reg;
    logic [UNIT_W-1:0]    head_unit_reg [NUM_BINS];

    logic [NEED_W-1:0]    need;
    logic                 too_large;
    logic [BIN_W-1:0]     bin_c;
    logic [BIN_W-1:0]     found_bin;
    logic                 found;
    logic [ADDR_W-1:0]    start;
    logic [AU_W-1:0]      free_unit;
    logic [LIM_W-1:0]     limit;
    logic                 free_ok;
    logic [BIN_W-1:0]     lvl_dn;
    logic [BIN_W-1:0]     free_tag;
    logic [UNIT_W-1:0]    page_unit;

    assign need      = NEED_W'(request_size) + NEED_W'(HDR_BYTES);
    assign too_large = need > NEED_W'(TOP_SIZE);

    always_comb
    begin
        bin_c = BIN_W'(TOP_BIN);
        for (int b = TOP_BIN; b >= 0; b--)
        begin
            if (NEED_W'(MIN_BLOCK << b) >= need)
            begin
                bin_c = BIN_W'(b);
            end
        end
        found     = 1'b0;
        found_bin = BIN_W'(TOP_BIN);
        for (int b = TOP_BIN; b >= 0; b--)
        begin
            if (head_valid_reg[b] && BIN_W'(b) >= bin_c)
            begin
                found     = 1'b1;
                found_bin = BIN_W'(b);
            end
        end
    end

    assign start     = release_address - ADDR_W'(HDR_BYTES);
    assign free_unit = start[ADDR_W-1:MIN_SHIFT];
    assign limit     = LIM_W'(chunks_reg) << CHUNK_SHIFT;
    assign free_ok   = (release_address >= ADDR_W'(HDR_BYTES))
                     && (start[MIN_SHIFT-1:0] == '0)
                     && ((LIM_W + AU_W)'(free_unit) < (LIM_W + AU_W)'(limit))
                     && ((AU_W + 32)'(free_unit) < (AU_W + 32)'(UNITS));
    assign lvl_dn    = lvl_reg - 1'b1;
    assign free_tag  = (int'(tag_rdata) > TOP_BIN) ? BIN_W'(TOP_BIN) : tag_rdata;
    assign page_unit = (UNIT_W'(chunks_reg) << CHUNK_SHIFT)
                     + (UNIT_W'(page_reg) << PAGE_SHIFT);

    assign in_ready   = (state_reg == S_IDLE) && !done_reg;
    assign res_valid  = done_reg;
    assign res        = res_reg;
    assign link_raddr = head_unit_reg[lvl_reg];
    assign tag_raddr  = unit_reg;

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = unit_reg;
        link_wdata = {head_valid_reg[lvl_dn], head_unit_reg[lvl_dn]};
        tag_we     = 1'b0;
        tag_waddr  = unit_reg;
        tag_wdata  = lvl_dn;
        case (state_reg)
            S_REFILL:
            begin
                link_we    = 1'b1;
                link_waddr = page_unit;
                link_wdata = {head_valid_reg[TOP_BIN], head_unit_reg[TOP_BIN]};
                tag_we     = 1'b1;
                tag_waddr  = page_unit;
                tag_wdata  = BIN_W'(TOP_BIN);
            end
            S_SPLIT:
            begin
                link_we = 1'b1;
                tag_we  = 1'b1;
            end
            S_GRANT:
            begin
                tag_we    = 1'b1;
                tag_wdata = bin_reg;
            end
            S_FREE_WB:
            begin
                link_we    = 1'b1;
                link_wdata = {head_valid_reg[free_tag], head_unit_reg[free_tag]};
                tag_we     = 1'b1;
                tag_wdata  = free_tag;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_REFILL:
            begin
                head_unit_reg[TOP_BIN] <= page_unit;
            end
            S_POP_WB:
            begin
                head_unit_reg[lvl_reg] <= link_rdata[UNIT_W-1:0];
            end
            S_SPLIT:
            begin
                head_unit_reg[lvl_dn] <= unit_reg;
            end
            S_FREE_WB:
            begin
                head_unit_reg[free_tag] <= unit_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            bin_reg        <= '0;
            lvl_reg        <= '0;
            unit_reg       <= '0;
            page_reg       <= '0;
            chunks_reg     <= '0;
            res_reg        <= '{addr: '0, size: '0, status: ST_OK};
            head_valid_reg <= '0;
        end
        else
        begin
            if (done_reg && res_ready)
            begin
                done_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (operation == OP_ALLOC)
                        begin
                            bin_reg <= bin_c;
                            if (too_large)
                            begin
                                res_reg  <= '{addr: '0, size: '0, status: ST_TOO_LARGE};
                                done_reg <= 1'b1;
                            end
                            else if (found)
                            begin
                                lvl_reg   <= found_bin;
                                state_reg <= S_POP_RD;
                            end
                            else if (int'(chunks_reg) < POOL_CHUNKS)
                            begin
                                lvl_reg   <= BIN_W'(TOP_BIN);
                                page_reg  <= '0;
                                state_reg <= S_REFILL;
                            end
                            else
                            begin
                                res_reg  <= '{addr: '0, size: '0, status: ST_EXHAUSTED};
                                done_reg <= 1'b1;
                            end
                        end
                        else if (free_ok)
                        begin
                            unit_reg  <= UNIT_W'(free_unit);
                            state_reg <= S_FREE_RD;
                        end
                        else
                        begin
                            res_reg  <= '{addr: '0, size: '0, status: ST_OK};
                            done_reg <= 1'b1;
                        end
                    end
                end
                S_REFILL:
                begin
                    head_valid_reg[TOP_BIN] <= 1'b1;
                    page_reg                <= page_reg + 1'b1;
                    if (page_reg == PAGE_W'(PAGES - 1))
                    begin
                        chunks_reg <= chunks_reg + 1'b1;
                        state_reg  <= S_POP_RD;
                    end
                end
                S_POP_RD:
                begin
                    unit_reg  <= head_unit_reg[lvl_reg];
                    state_reg <= S_POP_WB;
                end
                S_POP_WB:
                begin
                    head_valid_reg[lvl_reg] <= link_rdata[UNIT_W];
                    state_reg <= (lvl_reg == bin_reg) ? S_GRANT : S_SPLIT;
                end
                S_SPLIT:
                begin
                    // Lower half stays in the next bin down; the upper half goes on.
                    head_valid_reg[lvl_dn] <= 1'b1;
                    unit_reg  <= unit_reg + (UNIT_W'(1) << lvl_dn);
                    lvl_reg   <= lvl_dn;
                    if (lvl_dn == bin_reg)
                    begin
                        state_reg <= S_GRANT;
                    end
                end
                S_GRANT:
                begin
                    res_reg   <= '{addr: (ADDR_W'(unit_reg) << MIN_SHIFT) | ADDR_W'(HDR_BYTES),
                                   size: SIZE_W'(MIN_BLOCK) << bin_reg,
                                   status: ST_OK};
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_FREE_RD:
                begin
                    state_reg <= S_FREE_WB;
                end
                S_FREE_WB:
                begin
                    head_valid_reg[free_tag] <= 1'b1;
                    res_reg   <= '{addr: '0, size: SIZE_W'(MIN_BLOCK) << free_tag,
                                   status: ST_OK};
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_chunks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(chunks_reg) <= POOL_CHUNKS)
        else $error("chunk count above pool size");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !res_valid)
        else $error("word accepted while a result is pending");

    a_split_above_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (lvl_reg > bin_reg))
        else $error("split below the wanted bin");

    a_refill_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REFILL) |-> (int'(chunks_reg) < POOL_CHUNKS))
        else $error("refill with pool exhausted");

endmodule

// ===== sv/pow2_bin_block_allocator.sv =====
// Power-of-two bin block allocator, top level.
// Input channel (in_valid/in_ready) takes one word: operation, request_size
// and release_address. Operation 0 allocates request_size bytes plus an
// 8-byte header from one of eight LIFO free lists (32 to 4096 byte blocks);
// operation 1 returns the block whose payload starts at release_address.
// Output channel (out_valid/out_ready) gives exactly one word per input word:
// granted_address, granted_size and status (0 ok, 1 pool exhausted,
// 2 request too large).
// A rejected word gets its result straight from the idle state; a free reads
// the block's tag and pushes it; an allocate pops a bin and splits one level
// at a time (up to seven) down to the wanted bin, first carving a 64 KiB chunk
// into 4 KiB pages when no bin fits. Items are handled one at a time; the
// sequencer steps through the link and tag memories before it takes the next.
// Reset empties every bin and the chunk count; the memories need no clearing.
// A stalled receiver holds the result in the output register; the next word
// is accepted there, and its result waits until that register frees up.
module pow2_bin_block_allocator
    import pba_pkg::*;
#(
    parameter int POOL_CHUNKS = POOL_CHUNKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [REQ_W-1:0]   request_size,
    input  logic [ADDR_W-1:0]  release_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  granted_address,
    output logic [SIZE_W-1:0]  granted_size,
    output logic [STAT_W-1:0]  status
);

    localparam int UNITS  = POOL_CHUNKS * CHUNK_UNITS;
    localparam int UNIT_W = $clog2(UNITS);

    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               link_we;
    logic [UNIT_W-1:0]  link_waddr;
    logic [UNIT_W:0]    link_wdata;
    logic [UNIT_W-1:0]  link_raddr;
    logic [UNIT_W:0]    link_rdata;
    logic               tag_we;
    logic [UNIT_W-1:0]  tag_waddr;
    logic [BIN_W-1:0]   tag_wdata;
    logic [UNIT_W-1:0]  tag_raddr;
    logic [BIN_W-1:0]   tag_rdata;

    pba_ctrl #(
        .POOL_CHUNKS (POOL_CHUNKS),
        .UNITS       (UNITS),
        .UNIT_W      (UNIT_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .request_size    (request_size),
        .release_address (release_address),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .link_we         (link_we),
        .link_waddr      (link_waddr),
        .link_wdata      (link_wdata),
        .link_raddr      (link_raddr),
        .link_rdata      (link_rdata),
        .tag_we          (tag_we),
        .tag_waddr       (tag_waddr),
        .tag_wdata       (tag_wdata),
        .tag_raddr       (tag_raddr),
        .tag_rdata       (tag_rdata)
    );

    pba_ram #(
        .WIDTH (UNIT_W + 1),
        .DEPTH (UNITS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    pba_ram #(
        .WIDTH (BIN_W),
        .DEPTH (UNITS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    pba_outbuf u_outbuf (
        .clk             (clk),
        .rst_n           (rst_n),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_address (granted_address),
        .granted_size    (granted_size),
        .status          (status)
    );

endmodule

// ===== bench/pow2_bin_block_allocator_check.sv =====
// Checker for the power-of-two bin block allocator: watches both channels,
// predicts each result word from its own copy of the free lists and compares.
// Depends on pba_pkg.
`timescale 1ns / 100ps

module pow2_bin_block_allocator_check
    import pba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              operation,
    input  logic [REQ_W-1:0]  request_size,
    input  logic [ADDR_W-1:0] release_address,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [ADDR_W-1:0] granted_address,
    input  logic [SIZE_W-1:0] granted_size,
    input  logic [STAT_W-1:0] status,
    output int                mismatches,
    output int                pending
);

    localparam int UNITS  = POOL_CHUNKS_DEF * CHUNK_UNITS;
    localparam int UNIT_W = $clog2(UNITS);

    // Bit UNIT_W of a link marks it valid.
    logic [UNIT_W:0]  free_heads [NUM_BINS];
    logic [UNIT_W:0]  free_links [UNITS];
    logic [BIN_W-1:0] block_tags [UNITS];
    int               chunks_added;
    result_t          grant_queue[$];

    assign pending = grant_queue.size();

    task automatic push_free(input int unsigned unit, input int unsigned bin);
        free_links[unit] = free_heads[bin];
        block_tags[unit] = bin[BIN_W-1:0];
        free_heads[bin]  = {1'b1, unit[UNIT_W-1:0]};
    endtask

    task automatic predict_grant(input logic op, input logic [REQ_W-1:0] req,
                                 input logic [ADDR_W-1:0] ra, output result_t r);
        int unsigned need, bin, j, k, unit, start, tag;
        bit          found;
        r = '{addr: '0, size: '0, status: ST_OK};
        if (op == OP_ALLOC) begin
            need = req + HDR_BYTES;
            if (need < 16)
                need = 16;
            if (need > TOP_SIZE) begin
                r.status = ST_TOO_LARGE;
            end
            else begin
                bin = 0;
                while ((MIN_BLOCK << bin) < need && bin < TOP_BIN)
                    bin++;
                found = 0;
                for (j = bin; j < NUM_BINS; j++)
                begin
                    if (free_heads[j][UNIT_W]) begin
                        found = 1;
                        break;
                    end
                end
                if (!found && chunks_added < POOL_CHUNKS_DEF) begin
                    // A new chunk goes in as pages; the highest page ends on top.
                    for (k = 0; k < PAGES; k++)
                        push_free(chunks_added * CHUNK_UNITS + k * PAGE_UNITS, TOP_BIN);
                    chunks_added++;
                    j = TOP_BIN;
                    found = 1;
                end
                if (!found) begin
                    r.status = ST_EXHAUSTED;
                end
                else begin
                    unit = free_heads[j][UNIT_W-1:0];
                    free_heads[j] = free_links[unit];
                    // Lower halves stay on the lists, the upper half goes on.
                    for (k = j; k > bin; k--)
                    begin
                        push_free(unit, k - 1);
                        unit += 1 << (k - 1);
                    end
                    block_tags[unit] = bin[BIN_W-1:0];
                    r.addr = unit * MIN_BLOCK + HDR_BYTES;
                    r.size = MIN_BLOCK << bin;
                end
            end
        end
        else if (ra >= HDR_BYTES) begin
            start = ra - HDR_BYTES;
            unit  = start / MIN_BLOCK;
            if (start % MIN_BLOCK == 0 && unit < chunks_added * CHUNK_UNITS) begin
                tag = block_tags[unit];
                if (tag > TOP_BIN)
                    tag = TOP_BIN;
                push_free(unit, tag);
                r.size = MIN_BLOCK << tag;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            for (int b = 0; b < NUM_BINS; b++)
                free_heads[b] = '0;
            chunks_added = 0;
            mismatches   = 0;
            grant_queue.delete();
        end
        else begin
            if (in_valid && in_ready) begin
                predict_grant(operation, request_size, release_address, want);
                grant_queue.push_back(want);
            end
            if (out_valid && out_ready) begin
                if (grant_queue.size() == 0) begin
                    $error("result word with nothing expected: addr %0d size %0d status %0d",
                           granted_address, granted_size, status);
                    mismatches++;
                end
                else begin
                    want = grant_queue.pop_front();
                    if (granted_address !== want.addr || granted_size !== want.size
                        || status !== want.status)
                        mismatches++;
                    if (granted_address !== want.addr)
                        $error("granted_address expected %0d actual %0d",
                               want.addr, granted_address);
                    if (granted_size !== want.size)
                        $error("granted_size expected %0d actual %0d", want.size, granted_size);
                    if (status !== want.status)
                        $error("status expected %0d actual %0d", want.status, status);
                end
            end
        end
    end

endmodule

// ===== bench/pow2_bin_block_allocator_test.sv =====
// Top of the allocator bench: clock, reset, stimulus and verdict.
// Depends on pba_pkg, pow2_bin_block_allocator and its checker module.
`timescale 1ns / 100ps

module pow2_bin_block_allocator_test;
    import pba_pkg::*;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_ready;
    logic              operation = OP_ALLOC;
    logic [REQ_W-1:0]  request_size = '0;
    logic [ADDR_W-1:0] release_address = '0;
    logic              out_valid;
    logic              out_ready = 0;
    logic [ADDR_W-1:0] granted_address;
    logic [SIZE_W-1:0] granted_size;
    logic [STAT_W-1:0] status;
    int                mismatches;
    int                pending;

    int                send_idle = 0;
    int                recv_stall = 0;
    logic [ADDR_W-1:0] live_blocks[$];
    logic [ADDR_W-1:0] ever_granted[$];

    always #2 clk = ~clk;

    pow2_bin_block_allocator i_dut (.*);

    pow2_bin_block_allocator_check i_check (.*);

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall);
        // Remember granted blocks so later frees name real ones.
        if (out_valid && out_ready && status == ST_OK && granted_address != 0) begin
            live_blocks.push_back(granted_address);
            ever_granted.push_back(granted_address);
        end
    end

    task automatic send_word(input logic op, input logic [REQ_W-1:0] req,
                             input logic [ADDR_W-1:0] ra);
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid        <= 1;
        operation       <= op;
        request_size    <= req;
        release_address <= ra;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drops valid and waits, away from the clock edge, until every result is back.
    task automatic drain_results();
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] bad_release();
        logic [ADDR_W-1:0] ra;
        if ($urandom_range(3) == 0)
            return $urandom_range(0, HDR_BYTES - 1);
        ra = $urandom;
        if (ra[MIN_SHIFT-1:0] == HDR_BYTES[MIN_SHIFT-1:0])
            ra[0] = ~ra[0];
        return ra;
    endfunction

    task automatic random_word(input int alloc_pct);
        int                r, idx, sh;
        logic [ADDR_W-1:0] ra;
        r = $urandom_range(99);
        if (r < alloc_pct || live_blocks.size() == 0) begin
            sh = $urandom_range(3, 12);
            if ($urandom_range(19) == 0)
                send_word(OP_ALLOC, $urandom_range(TOP_SIZE - HDR_BYTES + 1, 65535), $urandom);
            else
                send_word(OP_ALLOC, $urandom_range(0, (1 << sh) - HDR_BYTES), $urandom);
        end
        else if (r < 96) begin
            idx = $urandom_range(live_blocks.size() - 1);
            ra  = live_blocks[idx];
            live_blocks.delete(idx);
            send_word(OP_FREE, $urandom, ra);
        end
        else if (r < 98) begin
            send_word(OP_FREE, $urandom, ever_granted[$urandom_range(ever_granted.size() - 1)]);
        end
        else begin
            send_word(OP_FREE, $urandom, bad_release());
        end
    endtask

    task automatic random_phase(input int idle, input int stall, input int alloc_pct,
                                input int count);
        send_idle  = idle;
        recv_stall = stall;
        repeat (count) random_word(alloc_pct);
    endtask

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Frees before any chunk exists, two of them below the header.
        send_word(OP_FREE, 0, HDR_BYTES);
        send_word(OP_FREE, 0, 0);
        send_word(OP_FREE, 0, 3);
        // Smallest request: refill plus a split through every bin.
        send_word(OP_ALLOC, 0, '1);
        send_word(OP_ALLOC, 24, 0);
        send_word(OP_ALLOC, 25, 0);
        send_word(OP_ALLOC, 4088, 0);
        send_word(OP_ALLOC, 4089, 0);
        send_word(OP_ALLOC, 16'hffff, 0);
        send_word(OP_ALLOC, 1000, 0);
        drain_results();
        send_word(OP_FREE, 0, live_blocks.pop_front());
        send_word(OP_FREE, '1, live_blocks.pop_back());
        // Second chunk is not yet in the pool.
        send_word(OP_FREE, 0, CHUNK_BYTES + HDR_BYTES);
        send_word(OP_FREE, 0, '1);
        // Double free.
        send_word(OP_FREE, 0, ever_granted[0]);
        send_word(OP_ALLOC, 8, 0);
        send_word(OP_ALLOC, 2000, 0);

        random_phase(0, 0, 60, 120);
        random_phase(78, 0, 60, 100);
        random_phase(0, 78, 55, 100);
        random_phase(78, 78, 55, 60);
        random_phase(22, 22, 60, 100);
        in_valid <= 0;
        drain_results();

        // Large blocks until the pool runs dry, then mostly frees.
        send_idle  = 0;
        recv_stall = 0;
        repeat (70) send_word(OP_ALLOC, $urandom_range(2100, TOP_SIZE - HDR_BYTES), $urandom);
        random_phase(22, 22, 15, 150);
        random_phase(0, 0, 55, 100);
        random_phase(22, 22, 55, 80);

        in_valid <= 0;
        drain_results();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pba_pkg.sv
sv/pba_ram.sv
sv/pba_outbuf.sv
sv/pba_ctrl.sv
sv/pow2_bin_block_allocator.sv
bench/pow2_bin_block_allocator_check.sv
bench/pow2_bin_block_allocator_test.sv
